[design/assert_macros.svh]
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/lusp_pkg.sv]
// Package: request codes, result kinds and Q16.16 arithmetic helpers.
`timescale 1ns / 1ps
package lusp_pkg;

    // Request codes carried by one input transaction.
    typedef enum logic [1:0] {
        REQ_WR_MAT = 2'd0,
        REQ_FACTOR = 2'd1,
        REQ_WR_RHS = 2'd2,
        REQ_SOLVE  = 2'd3
    } t_req;

    // Result kinds.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_SOL    = 1'b1;

    localparam logic [4:0] ORDER_RST = 5'd16;
    localparam logic [5:0] DV_STEPS  = 6'd48;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef logic signed [31:0] t_q;

    // Magnitude of a Q16.16 value, exact for the most negative code.
    function automatic logic [31:0] f_mag(input t_q a);
        return a[31] ? (32'd0 - 32'(a)) : 32'(a);
    endfunction

    // Round-to-nearest (ties up) of a full product, then saturate.
    function automatic t_q f_qmul_fin(input logic signed [65:0] prod);
        logic signed [65:0] p;
        logic signed [49:0] q;
        p = prod + 66'sd32768;
        q = p[65:16];
        if (q > 50'sd2147483647) return Q_MAX;
        if (q < -50'sd2147483648) return Q_MIN;
        return q[31:0];
    endfunction

    // Saturating subtraction.
    function automatic t_q f_qsub(input t_q a, input t_q b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) return d[32] ? Q_MIN : Q_MAX;
        return d[31:0];
    endfunction

endpackage

[design/lusp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module lusp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[design/lu_solve_scaled_pivot.sv]
// Top level: LU factor / solve sequencer with scaled partial pivoting.
//
// Input channel (i_in_valid / o_in_ready) carries requests: write matrix
// entry, factor, write rhs entry, solve. Output channel (o_out_valid /
// i_out_ready) carries results through one output register, so a result
// may wait while the next request is taken.
// Writes give no result. Factor runs the scale pass, then for each
// column a pivot search over the candidate rows, an optional row swap,
// and elimination: one divide per row below the pivot, then that row's
// updated entries. It ends with one status result, straight after the
// scale pass if a row is all zero. Solve copies the whole rhs store,
// runs forward then back substitution (a divide per row), then emits n
// solution elements. o_in_ready is high only while the sequencer is
// idle; all matrix and vector state sits in single-read-port RAMs.
// Reset clears the sequencer and output valid, and sets the order to 16;
// stores are undefined until written. A stalled receiver holds the
// sequencer at its emit step; nothing is dropped.
`timescale 1ns / 1ps
module lu_solve_scaled_pivot #(
    parameter int N = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [4:0]              i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_req_type,
    input  logic [3:0]              i_row_index,
    input  logic [3:0]              i_col_index,
    input  logic signed [31:0]      i_data_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_result_kind,
    output logic [3:0]              o_element_index,
    output logic signed [31:0]      o_result_value,
    output logic                    o_singular,
    output logic                    o_last
);
    import lusp_pkg::*;

    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int AW = 2 * IW;

    typedef enum logic [43:0] {
        S_IDLE    = 44'd1 << 0,  S_SC_RD   = 44'd1 << 1,  S_SC_ACC  = 44'd1 << 2,
        S_PV_RD0  = 44'd1 << 3,  S_PV_INIT = 44'd1 << 4,  S_PV_RD   = 44'd1 << 5,
        S_PV_M1   = 44'd1 << 6,  S_PV_M2   = 44'd1 << 7,  S_PV_M3   = 44'd1 << 8,
        S_PV_CMP  = 44'd1 << 9,  S_PERM    = 44'd1 << 10, S_SW_R1   = 44'd1 << 11,
        S_SW_R2   = 44'd1 << 12, S_SW_W1   = 44'd1 << 13, S_SW_W2   = 44'd1 << 14,
        S_EL_INIT = 44'd1 << 15, S_EL_PIV  = 44'd1 << 16, S_EL_RD   = 44'd1 << 17,
        S_EL_DIV  = 44'd1 << 18, S_EL_DW   = 44'd1 << 19, S_EL_K1   = 44'd1 << 20,
        S_EL_K2   = 44'd1 << 21, S_EL_K3   = 44'd1 << 22, S_EL_K4   = 44'd1 << 23,
        S_NEXT_I  = 44'd1 << 24, S_STATUS  = 44'd1 << 25, S_CP_RD   = 44'd1 << 26,
        S_CP_WR   = 44'd1 << 27, S_FW_P    = 44'd1 << 28, S_FW_P2   = 44'd1 << 29,
        S_FW_T    = 44'd1 << 30, S_FW_W    = 44'd1 << 31, S_DOT1    = 44'd1 << 32,
        S_DOT2    = 44'd1 << 33, S_DOT3    = 44'd1 << 34, S_DOT4    = 44'd1 << 35,
        S_FW_DONE = 44'd1 << 36, S_BK_I    = 44'd1 << 37, S_BK_I2   = 44'd1 << 38,
        S_BK_D    = 44'd1 << 39, S_BK_DIV  = 44'd1 << 40, S_BK_DW   = 44'd1 << 41,
        S_EM_RD   = 44'd1 << 42, S_EM_OUT  = 44'd1 << 43
    } t_state;

    function automatic logic [AW-1:0] f_ma(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return {r, c};
    endfunction

    // Control registers
    t_state r_state, n_state;
    logic [4:0] r_order;
    logic r_ovalid, n_ovalid;

    // Datapath registers
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [IW-1:0] r_piv, n_piv, r_p, n_p;
    logic [31:0] r_max, n_max, r_pmag, n_pmag, r_pscale, n_pscale;
    logic [31:0] r_cmag, n_cmag, r_cscale, n_cscale, r_iscale, n_iscale;
    logic r_zero, n_zero, r_back, n_back;
    logic signed [65:0] r_lhs, n_lhs, r_prod;
    t_q r_t, n_t, r_den, n_den, r_f, n_f, r_qm, n_qm;
    logic r_okind, n_okind, r_osing, n_osing, r_olast, n_olast;
    logic [3:0] r_oidx, n_oidx;
    t_q r_oval, n_oval;

    // Divider registers
    logic [31:0] r_dv_rem, r_dv_den;
    logic [47:0] r_dv_quo;
    logic [5:0]  r_dv_cnt;
    logic r_dv_neg, r_dv_nneg, r_dv_zden, r_dv_nzero;
    logic dv_start;
    t_q dv_num, dv_dnm, dv_res;
    logic dv_done;

    // RAM ports
    logic m_we, m_re, s_we, s_re, p_we, p_re, h_we, h_re, x_we, x_re;
    logic [AW-1:0] m_wa, m_ra;
    logic [IW-1:0] s_wa, s_ra, p_wa, p_ra, p_wd, p_rd, h_wa, h_ra, x_wa, x_ra;
    logic [31:0] m_wd, m_rd, s_wd, s_rd, h_wd, h_rd, x_wd, x_rd;

    // Multiplier operands
    logic signed [32:0] mul_a, mul_b;

    logic [CW-1:0] n_use, n_last, i_nx, j_nx, k_nx;
    logic [IW-1:0] ii, jj, kk;
    logic in_acc, out_free;
    logic [IW-1:0] in_row, in_col;
    logic row_ok, col_ok;
    logic [31:0] sc_mag, sc_max;

    lusp_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_mat (
        .i_clk, .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_re(m_re), .i_raddr(m_ra), .o_rdata(m_rd));
    lusp_ram #(.WIDTH(32), .DEPTH(N)) u_scale (
        .i_clk, .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_re(s_re), .i_raddr(s_ra), .o_rdata(s_rd));
    lusp_ram #(.WIDTH(IW), .DEPTH(N)) u_perm (
        .i_clk, .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_re(p_re), .i_raddr(p_ra), .o_rdata(p_rd));
    lusp_ram #(.WIDTH(32), .DEPTH(N)) u_rhs (
        .i_clk, .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_re(h_re), .i_raddr(h_ra), .o_rdata(h_rd));
    lusp_ram #(.WIDTH(32), .DEPTH(N)) u_sol (
        .i_clk, .i_we(x_we), .i_waddr(x_wa), .i_wdata(x_wd),
        .i_re(x_re), .i_raddr(x_ra), .o_rdata(x_rd));

    // Order in use, loop helpers
    always_comb begin
        if (r_order == 5'd0) begin
            n_use = CW'(1);
        end else if (32'(r_order) > N) begin
            n_use = CW'(N);
        end else begin
            n_use = CW'(r_order);
        end
    end
    assign n_last = n_use - CW'(1);
    assign i_nx = r_i + CW'(1);
    assign j_nx = r_j + CW'(1);
    assign k_nx = r_k + CW'(1);
    assign ii = r_i[IW-1:0];
    assign jj = r_j[IW-1:0];
    assign kk = r_k[IW-1:0];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;
    assign in_row = IW'(i_row_index);
    assign in_col = IW'(i_col_index);
    assign row_ok = 32'(i_row_index) < N;
    assign col_ok = 32'(i_col_index) < N;

    assign sc_mag = f_mag(m_rd);
    assign sc_max = (sc_mag > r_max) ? sc_mag : r_max;

    // Divider result: saturate magnitude and apply sign
    assign dv_done = (r_dv_cnt == 6'd0);
    always_comb begin
        if (r_dv_zden) begin
            dv_res = r_dv_nzero ? 32'sd0 : (r_dv_nneg ? Q_MIN : Q_MAX);
        end else if (!r_dv_neg) begin
            dv_res = (r_dv_quo > 48'h7fff_ffff) ? Q_MAX : r_dv_quo[31:0];
        end else begin
            dv_res = (r_dv_quo > 48'h8000_0000) ? Q_MIN : (32'd0 - r_dv_quo[31:0]);
        end
    end

    // Multiplier operand select
    always_comb begin
        case (r_state)
            S_PV_M2: begin
                mul_a = $signed({1'b0, r_cmag});
                mul_b = $signed({1'b0, r_pscale});
            end
            S_PV_M3: begin
                mul_a = $signed({1'b0, r_pmag});
                mul_b = $signed({1'b0, r_cscale});
            end
            S_EL_K2: begin
                mul_a = {r_f[31], r_f};
                mul_b = $signed({m_rd[31], m_rd});
            end
            default: begin
                mul_a = $signed({m_rd[31], m_rd});
                mul_b = $signed({x_rd[31], x_rd});
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid && !i_out_ready;
        n_i = r_i; n_j = r_j; n_k = r_k;
        n_piv = r_piv; n_p = r_p;
        n_max = r_max; n_pmag = r_pmag; n_pscale = r_pscale;
        n_cmag = r_cmag; n_cscale = r_cscale; n_iscale = r_iscale;
        n_zero = r_zero; n_back = r_back; n_lhs = r_lhs;
        n_t = r_t; n_den = r_den; n_f = r_f; n_qm = r_qm;
        n_okind = r_okind; n_osing = r_osing; n_olast = r_olast;
        n_oidx = r_oidx; n_oval = r_oval;
        dv_start = 1'b0; dv_num = m_rd; dv_dnm = r_den;
        m_we = 1'b0; m_wa = f_ma(ii, kk); m_wd = m_rd;
        m_re = 1'b0; m_ra = f_ma(ii, kk);
        s_we = 1'b0; s_wa = ii; s_wd = sc_max; s_re = 1'b0; s_ra = ii;
        p_we = 1'b0; p_wa = ii; p_wd = r_piv; p_re = 1'b0; p_ra = ii;
        h_we = 1'b0; h_wa = in_row; h_wd = i_data_value; h_re = 1'b0; h_ra = kk;
        x_we = 1'b0; x_wa = ii; x_wd = r_t; x_re = 1'b0; x_ra = ii;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_req_type)
                        REQ_WR_MAT: begin
                            m_we = row_ok && col_ok;
                            m_wa = f_ma(in_row, in_col);
                            m_wd = i_data_value;
                        end
                        REQ_FACTOR: begin
                            n_i = '0; n_j = '0; n_max = '0; n_zero = 1'b0;
                            n_state = S_SC_RD;
                        end
                        REQ_WR_RHS: begin
                            h_we = row_ok;
                        end
                        REQ_SOLVE: begin
                            n_k = '0;
                            n_state = S_CP_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // Row scale pass
            S_SC_RD: begin
                m_re = 1'b1; m_ra = f_ma(ii, jj);
                n_state = S_SC_ACC;
            end
            S_SC_ACC: begin
                if (r_j == n_last) begin
                    s_we = 1'b1;
                    n_zero = r_zero || (sc_max == 32'd0);
                    n_max = '0; n_j = '0;
                    if (r_i == n_last) begin
                        n_i = '0;
                        n_state = n_zero ? S_STATUS : S_PV_RD0;
                    end else begin
                        n_i = i_nx;
                        n_state = S_SC_RD;
                    end
                end else begin
                    n_max = sc_max; n_j = j_nx;
                    n_state = S_SC_RD;
                end
            end

            // Pivot search over rows below the diagonal
            S_PV_RD0: begin
                m_re = 1'b1; m_ra = f_ma(ii, ii);
                s_re = 1'b1;
                n_state = S_PV_INIT;
            end
            S_PV_INIT: begin
                n_pmag = f_mag(m_rd); n_pscale = s_rd; n_iscale = s_rd;
                n_piv = ii; n_j = i_nx;
                n_state = (i_nx == n_use) ? S_PERM : S_PV_RD;
            end
            S_PV_RD: begin
                m_re = 1'b1; m_ra = f_ma(jj, ii);
                s_re = 1'b1; s_ra = jj;
                n_state = S_PV_M1;
            end
            S_PV_M1: begin
                n_cmag = f_mag(m_rd); n_cscale = s_rd;
                n_state = S_PV_M2;
            end
            S_PV_M2: begin
                n_state = S_PV_M3;
            end
            S_PV_M3: begin
                n_lhs = r_prod;
                n_state = S_PV_CMP;
            end
            S_PV_CMP: begin
                if (r_lhs > r_prod) begin
                    n_piv = jj; n_pmag = r_cmag; n_pscale = r_cscale;
                end
                n_j = j_nx;
                n_state = (j_nx == n_use) ? S_PERM : S_PV_RD;
            end
            S_PERM: begin
                p_we = 1'b1;
                s_we = 1'b1; s_wa = r_piv; s_wd = r_iscale;
                n_k = '0;
                n_state = (r_piv != ii) ? S_SW_R1 : S_EL_INIT;
            end

            // Row swap
            S_SW_R1: begin
                m_re = 1'b1;
                n_state = S_SW_R2;
            end
            S_SW_R2: begin
                n_t = m_rd;
                m_re = 1'b1; m_ra = f_ma(r_piv, kk);
                n_state = S_SW_W1;
            end
            S_SW_W1: begin
                m_we = 1'b1;
                n_state = S_SW_W2;
            end
            S_SW_W2: begin
                m_we = 1'b1; m_wa = f_ma(r_piv, kk); m_wd = r_t;
                n_k = k_nx;
                n_state = (k_nx == n_use) ? S_EL_INIT : S_SW_R1;
            end

            // Elimination below the pivot
            S_EL_INIT: begin
                if (i_nx == n_use) begin
                    n_state = S_NEXT_I;
                end else begin
                    m_re = 1'b1; m_ra = f_ma(ii, ii);
                    n_j = i_nx;
                    n_state = S_EL_PIV;
                end
            end
            S_EL_PIV: begin
                n_den = m_rd;
                n_state = S_EL_RD;
            end
            S_EL_RD: begin
                m_re = 1'b1; m_ra = f_ma(jj, ii);
                n_state = S_EL_DIV;
            end
            S_EL_DIV: begin
                dv_start = 1'b1;
                n_state = S_EL_DW;
            end
            S_EL_DW: begin
                if (dv_done) begin
                    m_we = 1'b1; m_wa = f_ma(jj, ii); m_wd = dv_res;
                    n_f = dv_res; n_k = i_nx;
                    n_state = S_EL_K1;
                end
            end
            S_EL_K1: begin
                m_re = 1'b1;
                n_state = S_EL_K2;
            end
            S_EL_K2: begin
                m_re = 1'b1; m_ra = f_ma(jj, kk);
                n_state = S_EL_K3;
            end
            S_EL_K3: begin
                n_t = m_rd; n_qm = f_qmul_fin(r_prod);
                n_state = S_EL_K4;
            end
            S_EL_K4: begin
                m_we = 1'b1; m_wa = f_ma(jj, kk); m_wd = f_qsub(r_t, r_qm);
                n_k = k_nx;
                if (k_nx == n_use) begin
                    n_j = j_nx;
                    n_state = (j_nx == n_use) ? S_NEXT_I : S_EL_RD;
                end else begin
                    n_state = S_EL_K1;
                end
            end
            S_NEXT_I: begin
                n_i = i_nx;
                n_state = (i_nx == n_use) ? S_STATUS : S_PV_RD0;
            end
            S_STATUS: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_okind = KIND_STATUS; n_oidx = '0;
                    n_oval = '0; n_osing = r_zero; n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end

            // Solve: copy the whole rhs store, a swap may reach past the order
            S_CP_RD: begin
                h_re = 1'b1;
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                x_we = 1'b1; x_wa = kk; x_wd = h_rd;
                n_k = k_nx;
                if (k_nx == CW'(N)) begin
                    n_i = '0;
                    n_state = S_FW_P;
                end else begin
                    n_state = S_CP_RD;
                end
            end

            // Forward substitution with the recorded swaps
            S_FW_P: begin
                p_re = 1'b1;
                n_state = S_FW_P2;
            end
            S_FW_P2: begin
                n_p = p_rd;
                x_re = 1'b1; x_ra = p_rd;
                n_state = S_FW_T;
            end
            S_FW_T: begin
                n_t = x_rd;
                x_re = 1'b1;
                n_state = S_FW_W;
            end
            S_FW_W: begin
                x_we = 1'b1; x_wa = r_p; x_wd = x_rd;
                n_j = '0; n_back = 1'b0;
                n_state = (r_i == '0) ? S_FW_DONE : S_DOT1;
            end

            // Shared dot-product step for both substitutions
            S_DOT1: begin
                m_re = 1'b1; m_ra = f_ma(ii, jj);
                x_re = 1'b1; x_ra = jj;
                n_state = S_DOT2;
            end
            S_DOT2: begin
                n_state = S_DOT3;
            end
            S_DOT3: begin
                n_qm = f_qmul_fin(r_prod);
                n_state = S_DOT4;
            end
            S_DOT4: begin
                n_t = f_qsub(r_t, r_qm);
                n_j = j_nx;
                if (r_back) begin
                    n_state = (j_nx == n_use) ? S_BK_D : S_DOT1;
                end else begin
                    n_state = (j_nx == r_i) ? S_FW_DONE : S_DOT1;
                end
            end
            S_FW_DONE: begin
                x_we = 1'b1;
                if (i_nx == n_use) begin
                    n_state = S_BK_I;
                end else begin
                    n_i = i_nx;
                    n_state = S_FW_P;
                end
            end

            // Back substitution
            S_BK_I: begin
                x_re = 1'b1;
                n_state = S_BK_I2;
            end
            S_BK_I2: begin
                n_t = x_rd; n_j = i_nx; n_back = 1'b1;
                n_state = (i_nx == n_use) ? S_BK_D : S_DOT1;
            end
            S_BK_D: begin
                m_re = 1'b1; m_ra = f_ma(ii, ii);
                n_state = S_BK_DIV;
            end
            S_BK_DIV: begin
                dv_start = 1'b1; dv_num = r_t; dv_dnm = m_rd;
                n_state = S_BK_DW;
            end
            S_BK_DW: begin
                if (dv_done) begin
                    x_we = 1'b1; x_wd = dv_res;
                    if (r_i == '0) begin
                        n_k = '0;
                        n_state = S_EM_RD;
                    end else begin
                        n_i = r_i - CW'(1);
                        n_state = S_BK_I;
                    end
                end
            end

            // Emit solution elements in order
            S_EM_RD: begin
                x_re = 1'b1; x_ra = kk;
                n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_okind = KIND_SOL; n_oidx = 4'(r_k);
                    n_oval = x_rd; n_osing = 1'b0; n_olast = (k_nx == n_use);
                    n_k = k_nx;
                    n_state = (k_nx == n_use) ? S_IDLE : S_EM_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_order <= ORDER_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
        end
    end

    // Datapath registers and multiplier
    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_k <= n_k;
        r_piv <= n_piv; r_p <= n_p;
        r_max <= n_max; r_pmag <= n_pmag; r_pscale <= n_pscale;
        r_cmag <= n_cmag; r_cscale <= n_cscale; r_iscale <= n_iscale;
        r_zero <= n_zero; r_back <= n_back; r_lhs <= n_lhs;
        r_t <= n_t; r_den <= n_den; r_f <= n_f; r_qm <= n_qm;
        r_okind <= n_okind; r_osing <= n_osing; r_olast <= n_olast;
        r_oidx <= n_oidx; r_oval <= n_oval;
        r_prod <= mul_a * mul_b;
    end

    // Restoring divider on magnitudes: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_cnt <= '0;
        end else if (dv_start) begin
            r_dv_cnt <= (dv_dnm == 32'sd0) ? 6'd0 : DV_STEPS;
        end else if (r_dv_cnt != 6'd0) begin
            r_dv_cnt <= r_dv_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [32:0] rem_sh;
        logic ge;
        rem_sh = {r_dv_rem, r_dv_quo[47]};
        ge = rem_sh >= {1'b0, r_dv_den};
        if (dv_start) begin
            r_dv_rem <= '0;
            r_dv_quo <= {f_mag(dv_num), 16'd0};
            r_dv_den <= f_mag(dv_dnm);
            r_dv_neg <= dv_num[31] ^ dv_dnm[31];
            r_dv_nneg <= dv_num[31];
            r_dv_zden <= (dv_dnm == 32'sd0);
            r_dv_nzero <= (dv_num == 32'sd0);
        end else if (r_dv_cnt != 6'd0) begin
            r_dv_rem <= ge ? 32'(rem_sh - {1'b0, r_dv_den}) : rem_sh[31:0];
            r_dv_quo <= {r_dv_quo[46:0], ge};
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_result_kind = r_okind;
    assign o_element_index = r_oidx;
    assign o_result_value = r_oval;
    assign o_singular = r_osing;
    assign o_last = r_olast;
endmodule

[design/lusp_chk.sv]
// Port-level checker for the LU solver, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lusp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_req_type,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_result_kind,
    input logic [3:0]  o_element_index,
    input logic [31:0] o_result_value,
    input logic        o_singular,
    input logic        o_last
);
    import lusp_pkg::*;

    // A status result is a single transaction with an empty payload
    `CHK_IMPL(a_status_form, i_clk, i_rst_n, o_out_valid && (o_result_kind == KIND_STATUS), o_last && (o_element_index == 4'd0) && (o_result_value == 32'd0))

    // Solution elements never flag singularity
    `CHK_IMPL(a_sol_not_sing, i_clk, i_rst_n, o_out_valid && (o_result_kind == KIND_SOL), !o_singular)

    // Factor and solve requests busy the sequencer right away
    `CHK_NEXT(a_busy_after_cmd, i_clk, i_rst_n, i_in_valid && o_in_ready && ((i_req_type == REQ_FACTOR) || (i_req_type == REQ_SOLVE)), !o_in_ready)

    // A stalled result holds
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_result_value) && $stable(o_last))
endmodule

bind lu_solve_scaled_pivot lusp_chk u_lusp_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready),
    .i_req_type(i_req_type),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_result_kind(o_result_kind),
    .o_element_index(o_element_index),
    .o_result_value(o_result_value),
    .o_singular(o_singular),
    .o_last(o_last)
);

[bench/lu_solve_scaled_pivot_test.sv]
// Self-checking testbench for the scaled-pivot LU factor/solve block.
`timescale 1ns / 1ps
module lu_solve_scaled_pivot_test;
    import lusp_pkg::*;

    localparam int NMAX = 16;
    localparam int LIMIT_CYCLES = 2000000;

    typedef struct {
        t_req                req;
        logic [3:0]          row;
        logic [3:0]          col;
        logic signed [31:0]  data;
    } t_lu_request;

    typedef struct {
        logic                kind;
        logic [3:0]          idx;
        logic signed [31:0]  val;
        logic                sing;
        logic                last;
    } t_lu_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [4:0]          i_cfg_wdata = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_req_type = '0;
    logic [3:0]          i_row_index = '0;
    logic [3:0]          i_col_index = '0;
    logic signed [31:0]  i_data_value = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_result_kind;
    logic [3:0]          o_element_index;
    logic signed [31:0]  o_result_value;
    logic                o_singular;
    logic                o_last;

    lu_solve_scaled_pivot #(.N(NMAX)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_req_type(i_req_type), .i_row_index(i_row_index),
        .i_col_index(i_col_index), .i_data_value(i_data_value),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_result_kind(o_result_kind), .o_element_index(o_element_index),
        .o_result_value(o_result_value), .o_singular(o_singular), .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_lu_request  pending_reqs[$];
    t_lu_result   expected_results[$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    // Shadow of the block's state
    logic signed [31:0] sh_lu[NMAX*NMAX];
    logic [31:0]        sh_scale[NMAX];
    logic [3:0]         sh_perm[NMAX];
    logic signed [31:0] sh_rhs[NMAX];
    logic signed [31:0] sh_sol[NMAX];
    logic [4:0]         sh_order = ORDER_RST;
    logic               last_singular;

    // Stimulus bookkeeping: never read a store entry that was never written
    bit                 mat_written[NMAX*NMAX];
    bit                 rhs_written[NMAX];
    int                 perm_valid_n = 0;

    // Q16.16 saturating arithmetic
    function automatic logic signed [31:0] q_sat(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return q_sat(p >>> 16);
    endfunction

    function automatic logic signed [31:0] q_div(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        if (b == 0) begin
            if (a == 0) return 0;
            return a > 0 ? 32'sh7fff_ffff : 32'sh8000_0000;
        end
        return q_sat((longint'(a) * 64'sd65536) / longint'(b));
    endfunction

    function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return q_sat(longint'(a) - longint'(b));
    endfunction

    function automatic logic [31:0] q_mag(input logic signed [31:0] a);
        return a[31] ? 32'd0 - a : a;
    endfunction

    function automatic int eff_order();
        if (sh_order == 0) return 1;
        if (sh_order > NMAX) return NMAX;
        return sh_order;
    endfunction

    // Factor in place; returns 1 on an all-zero row
    function automatic bit lu_factor(input int n);
        logic [31:0]        m;
        logic [31:0]        v;
        bit                 zero_row;
        int                 piv;
        longint unsigned    lhs, rhs;
        logic signed [31:0] t, f;
        zero_row = 0;
        for (int i = 0; i < n; i++) begin
            m = 0;
            for (int j = 0; j < n; j++) begin
                v = q_mag(sh_lu[i*NMAX+j]);
                if (v > m) m = v;
            end
            sh_scale[i] = m;
            if (m == 0) zero_row = 1;
        end
        if (zero_row) return 1;
        for (int i = 0; i < n; i++) begin
            piv = i;
            for (int j = i + 1; j < n; j++) begin
                lhs = longint'(q_mag(sh_lu[j*NMAX+i])) * longint'(sh_scale[piv]);
                rhs = longint'(q_mag(sh_lu[piv*NMAX+i])) * longint'(sh_scale[j]);
                if (lhs > rhs) piv = j;
            end
            if (piv != i) begin
                for (int k = 0; k < n; k++) begin
                    t = sh_lu[i*NMAX+k];
                    sh_lu[i*NMAX+k] = sh_lu[piv*NMAX+k];
                    sh_lu[piv*NMAX+k] = t;
                end
            end
            sh_perm[i] = piv[3:0];
            sh_scale[piv] = sh_scale[i];
            for (int j = i + 1; j < n; j++) begin
                f = q_div(sh_lu[j*NMAX+i], sh_lu[i*NMAX+i]);
                sh_lu[j*NMAX+i] = f;
                for (int k = i + 1; k < n; k++)
                    sh_lu[j*NMAX+k] = q_sub(sh_lu[j*NMAX+k], q_mul(f, sh_lu[i*NMAX+k]));
            end
        end
        return 0;
    endfunction

    // Permute rhs, forward then back substitution into sh_sol
    task automatic lu_substitute(input int n);
        logic signed [31:0] work[NMAX];
        logic signed [31:0] t;
        int                 p;
        work = sh_rhs;
        for (int i = 0; i < n; i++) begin
            p = sh_perm[i];
            t = work[p];
            work[p] = work[i];
            for (int j = 0; j < i; j++)
                t = q_sub(t, q_mul(sh_lu[i*NMAX+j], sh_sol[j]));
            sh_sol[i] = t;
        end
        for (int i = n - 1; i >= 0; i--) begin
            t = sh_sol[i];
            for (int j = i + 1; j < n; j++)
                t = q_sub(t, q_mul(sh_lu[i*NMAX+j], sh_sol[j]));
            sh_sol[i] = q_div(t, sh_lu[i*NMAX+i]);
        end
    endtask

    // Queue one request and the results it should produce
    task automatic issue(input t_req req, input int row, input int col,
                         input logic signed [31:0] data);
        t_lu_request r;
        t_lu_result  e;
        int          n;
        r.req = req; r.row = row[3:0]; r.col = col[3:0]; r.data = data;
        pending_reqs.push_back(r);
        n = eff_order();
        case (req)
            REQ_WR_MAT: begin
                sh_lu[row*NMAX+col] = data;
                mat_written[row*NMAX+col] = 1;
            end
            REQ_WR_RHS: begin
                sh_rhs[row] = data;
                rhs_written[row] = 1;
            end
            REQ_FACTOR: begin
                last_singular = lu_factor(n);
                if (!last_singular && n > perm_valid_n) perm_valid_n = n;
                e.kind = KIND_STATUS; e.idx = 0; e.val = 0;
                e.sing = last_singular; e.last = 1;
                expected_results.push_back(e);
            end
            default: begin
                lu_substitute(n);
                for (int i = 0; i < n; i++) begin
                    e.kind = KIND_SOL; e.idx = i[3:0]; e.val = sh_sol[i];
                    e.sing = 0; e.last = (i == n - 1);
                    expected_results.push_back(e);
                end
            end
        endcase
    endtask

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(9))
            0: return 0;
            1: return 32'sh8000_0000;
            2: return 32'sh7fff_ffff;
            3: return $urandom;
            default: return $signed($urandom_range(32'h7ffff)) - 32'sh40000;
        endcase
    endfunction

    function automatic bit solve_allowed();
        int n;
        n = eff_order();
        if (perm_valid_n < n) return 0;
        for (int i = 0; i < n; i++)
            if (!rhs_written[i]) return 0;
        return 1;
    endfunction

    task automatic load_rhs_and_solve();
        for (int i = 0; i < eff_order(); i++)
            issue(REQ_WR_RHS, i, $urandom_range(15), rand_q());
        issue(REQ_SOLVE, $urandom_range(15), $urandom_range(15), $urandom);
    endtask

    // One random sequence: well-formed, with a zero row, or stray writes
    task automatic random_sequence();
        int n, zrow, kind;
        n = eff_order();
        kind = $urandom_range(9);
        if (kind < 7) begin
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++)
                    issue(REQ_WR_MAT, r, c, rand_q());
            issue(REQ_FACTOR, $urandom_range(15), $urandom_range(15), $urandom);
            if (!last_singular) begin
                load_rhs_and_solve();
                if ($urandom_range(2) == 0) load_rhs_and_solve();
            end
        end else if (kind < 9) begin
            zrow = $urandom_range(n - 1);
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++)
                    issue(REQ_WR_MAT, r, c, (r == zrow) ? 32'sd0 : rand_q());
            issue(REQ_FACTOR, 0, 0, 0);
            if (solve_allowed()) issue(REQ_SOLVE, 0, 0, 0);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(1)) issue(REQ_WR_MAT, $urandom_range(15),
                                             $urandom_range(15), rand_q());
                else issue(REQ_WR_RHS, $urandom_range(15), $urandom_range(15), rand_q());
            end
        end
    endtask

    task automatic load_2x2(input logic signed [31:0] a00, input logic signed [31:0] a01,
                            input logic signed [31:0] a10, input logic signed [31:0] a11);
        issue(REQ_WR_MAT, 0, 0, a00);
        issue(REQ_WR_MAT, 0, 1, a01);
        issue(REQ_WR_MAT, 1, 0, a10);
        issue(REQ_WR_MAT, 1, 1, a11);
        issue(REQ_FACTOR, 0, 0, 0);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_order(input logic [4:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sh_order = value;
        @(negedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge i_clk);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
        @(negedge i_clk);
    endtask

    // Input driver
    always @(posedge i_clk) begin
        t_lu_request r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                r = pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= r.req;
                i_row_index <= r.row;
                i_col_index <= r.col;
                i_data_value <= r.data;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_lu_result e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result kind=%0d idx=%0d val=%h sing=%0d last=%0d",
                             $time, o_result_kind, o_element_index, o_result_value,
                             o_singular, o_last);
                end else begin
                    e = expected_results.pop_front();
                    if (o_result_kind !== e.kind || o_element_index !== e.idx ||
                        o_result_value !== e.val || o_singular !== e.sing ||
                        o_last !== e.last) begin
                        error_count++;
                        $display("%0t: mismatch expected kind=%0d idx=%0d val=%h sing=%0d last=%0d",
                                 $time, e.kind, e.idx, e.val, e.sing, e.last);
                        $display("%0t:          actual   kind=%0d idx=%0d val=%h sing=%0d last=%0d",
                                 $time, o_result_kind, o_element_index, o_result_value,
                                 o_singular, o_last);
                    end
                end
            end
        end
    end

    // Run limit
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("lu_solve_scaled_pivot_test: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: order 2, no idling
        write_order(5'd2);
        load_2x2(32'sh0, 32'sh10000, 32'sh0, 32'sh20000);    // zero pivot column
        issue(REQ_WR_RHS, 0, 0, 32'sh30000);
        issue(REQ_WR_RHS, 1, 0, 32'sh8000);
        issue(REQ_SOLVE, 0, 0, 0);
        load_2x2(32'sh50000, 32'sh0, 32'sh0, 32'sh0);        // all-zero row
        issue(REQ_SOLVE, 15, 15, 32'shffff_ffff);
        load_2x2(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
        issue(REQ_WR_RHS, 0, 15, 32'sh8000_0000);
        issue(REQ_WR_RHS, 1, 15, 32'sh7fff_ffff);
        issue(REQ_SOLVE, 0, 0, 0);
        load_2x2(32'sh20000, 32'sh10000, 32'sh10000, 32'sh30000);
        issue(REQ_SOLVE, 3, 7, 32'sh1234_5678);
        wait_drained();

        // Random phases across orders and idling patterns
        write_order(5'd0);
        set_idling(59, 0);
        repeat (3) random_sequence();
        wait_drained();

        write_order(5'd3);
        set_idling(0, 59);
        repeat (2) random_sequence();
        wait_drained();

        write_order(5'd4);
        set_idling(26, 26);
        random_sequence();
        wait_drained();

        // Full order with the largest positive value on the diagonal
        write_order(5'd31);
        set_idling(26, 26);
        for (int r = 0; r < NMAX; r++)
            for (int c = 0; c < NMAX; c++)
                issue(REQ_WR_MAT, r, c, (r == c) ? 32'sh7fff_ffff : rand_q());
        issue(REQ_FACTOR, 0, 0, 0);
        if (!last_singular) load_rhs_and_solve();
        wait_drained();

        write_order(5'd2);
        set_idling(0, 0);
        repeat (2) random_sequence();
        wait_drained();

        repeat (100) @(posedge i_clk);
        if (error_count == 0)
            $display("lu_solve_scaled_pivot_test: done, clean");
        else
            $display("lu_solve_scaled_pivot_test: done, errors");
        $finish;
    end
endmodule
